// ===== rtl/shot_heat_budget_limiter_assert.svh =====
// assertion macros for the shot heat budget limiter
// used by the top level, no other dependencies

`ifndef SHOT_HEAT_BUDGET_LIMITER_ASSERT_SVH
`define SHOT_HEAT_BUDGET_LIMITER_ASSERT_SVH

// same-cycle implication under the block reset
`define SHL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the block reset
`define SHL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/shl_pkg.sv =====
// shared types and constants for the shot heat budget limiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shl_pkg;

	// field widths
	localparam int unsigned SHOT_W     = 10;
	localparam int unsigned MARGIN_W   = 16;
	localparam int unsigned COOL_W     = 16;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned PERIOD_W   = 20;
	localparam int unsigned AGE_W      = 32;
	localparam int unsigned HEAT_W     = 40;
	localparam int unsigned SHOTS_W    = 16;

	// shared multiplier: 16 x 20 bits
	localparam int unsigned MUL_A_W    = 16;
	localparam int unsigned MUL_B_W    = 20;
	localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

	// serial divider: divisor is shot_heat x 1e6, at least 2^19, so quotient < 2^17
	localparam int unsigned DIVIDEND_W = PROD_W;
	localparam int unsigned DIVISOR_W  = 30;
	localparam int unsigned QUOT_W     = 17;
	localparam int unsigned DCNT_W     = $clog2(QUOT_W + 1);

	// stream and configuration port widths
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [MUL_B_W-1:0] MICRO_PER_UNIT = MUL_B_W'(1000000);

	// reset values of the configuration registers
	localparam logic [SHOT_W-1:0]   RST_SHOT_HEAT   = SHOT_W'(10);
	localparam logic [SHOT_W-1:0]   RST_EXTRA_HEAT  = SHOT_W'(0);
	localparam logic [MARGIN_W-1:0] RST_MARGIN      = MARGIN_W'(0);
	localparam logic [COOL_W-1:0]   RST_FB_COOLING  = COOL_W'(40);
	localparam logic [LIMIT_W-1:0]  RST_FB_LIMIT    = LIMIT_W'(240);
	localparam logic [AGE_W-1:0]    RST_STALE_AFTER = AGE_W'(500000);

	// item kinds
	localparam logic OP_STATUS = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHOT_HEAT   = 3'd0,
		REG_EXTRA_HEAT  = 3'd1,
		REG_MARGIN      = 3'd2,
		REG_FB_COOLING  = 3'd3,
		REG_FB_LIMIT    = 3'd4,
		REG_STALE_AFTER = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP,
		ST_COOL,
		ST_GAIN,
		ST_NEED,
		ST_BUDGET,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/shot_heat_budget_limiter.sv =====
// a tick's result goes through the drop, cool, gain, need and budget steps, then the
// serial divider unless the budget is spent or shot_heat is zero, then the done step
// status items can be taken one per cycle, ticks one at a time; s_tready is high
// only while the sequencer is idle, and a finished tick holds in its last step while the
// previous result still waits in the output register
// reset: arst_n clears heat, fire history, held status and age, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

`include "shot_heat_budget_limiter_assert.svh"

// leaky-bucket shot limiter, one shared 16 x 20 multiplier under a small sequencer
// depends on shl_pkg, shl_div and the assertion header
module shot_heat_budget_limiter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [shl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [shl_pkg::CFG_DATA_W-1:0]      cfg_data,

	// input stream
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	// status_cooling[15:0], status_limit[31:16], tick_period_us[51:32], fire_level[52]
	input  wire logic [shl_pkg::IN_TDATA_W-1:0]      s_tdata,
	// opcode[0]
	input  wire logic [0:0]                          s_tuser,

	// result stream
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	// shots_allowed[15:0]
	output      logic [shl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// status_fresh[0]
	output      logic [0:0]                          m_tuser
);

	// input field unpacking
	logic [shl_pkg::COOL_W-1:0]   in_cooling;
	logic [shl_pkg::LIMIT_W-1:0]  in_limit;
	logic [shl_pkg::PERIOD_W-1:0] in_period;
	logic                         in_fire;
	logic                         in_opcode;

	assign in_cooling = s_tdata[15:0];
	assign in_limit   = s_tdata[31:16];
	assign in_period  = s_tdata[51:32];
	assign in_fire    = s_tdata[52];
	assign in_opcode  = s_tuser[0];

	// configuration registers
	logic [shl_pkg::SHOT_W-1:0]   shot_heat_q;
	logic [shl_pkg::SHOT_W-1:0]   extra_heat_q;
	logic [shl_pkg::MARGIN_W-1:0] margin_q;
	logic [shl_pkg::COOL_W-1:0]   fb_cooling_q;
	logic [shl_pkg::LIMIT_W-1:0]  fb_limit_q;
	logic [shl_pkg::AGE_W-1:0]    stale_after_q;

	// block state
	logic [shl_pkg::HEAT_W-1:0]   heat_q;
	logic                         fire_prev_q;
	logic [shl_pkg::COOL_W-1:0]   held_cooling_q;
	logic [shl_pkg::LIMIT_W-1:0]  held_limit_q;
	logic                         held_valid_q;
	logic [shl_pkg::AGE_W-1:0]    held_age_q;

	// per-tick working registers
	shl_pkg::state_t              state_q, state_d;
	logic [shl_pkg::PERIOD_W-1:0] period_q;
	logic                         fire_q;
	logic                         fresh_q;
	logic [shl_pkg::PROD_W-1:0]   prod_q;
	logic [shl_pkg::HEAT_W:0]     need_q;
	logic [shl_pkg::PROD_W-1:0]   diff_q;
	logic [shl_pkg::SHOTS_W-1:0]  shots_q;
	logic                         m_tvalid_q;
	logic [shl_pkg::SHOTS_W-1:0]  m_shots_q;
	logic                         m_fresh_q;

	// shared multiplier operands
	logic [shl_pkg::MUL_A_W-1:0]  mul_a;
	logic [shl_pkg::MUL_B_W-1:0]  mul_b;
	logic                         div_start;

	logic                         in_xfer;
	logic                         out_xfer;
	logic                         out_free;

	// age update and freshness test, done in the transfer cycle of a tick
	logic [shl_pkg::AGE_W:0]      age_sum;
	logic [shl_pkg::AGE_W-1:0]    age_next;
	logic                         fresh_next;

	// heat arithmetic
	logic [shl_pkg::HEAT_W:0]     heat_sum;
	logic                         budget_spent;
	logic [shl_pkg::SHOT_W:0]     shot_total;

	logic [shl_pkg::QUOT_W-1:0]   quot;
	shl_pkg::div_stat_t           div_stat;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid_q && m_tready;
	// output register can take a result when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	assign age_sum    = {1'b0, held_age_q} + (shl_pkg::AGE_W + 1)'(in_period);
	assign age_next   = age_sum[shl_pkg::AGE_W] ? '1 : age_sum[shl_pkg::AGE_W-1:0];
	// zero stale limit means the held status never times out
	assign fresh_next = held_valid_q &&
	                    ((stale_after_q == '0) || (age_next <= stale_after_q));

	assign heat_sum     = {1'b0, heat_q} + (shl_pkg::HEAT_W + 1)'(prod_q);
	// in the budget step prod_q holds limit x 1e6
	assign budget_spent = (shl_pkg::HEAT_W + 1)'(prod_q) <= need_q;
	assign shot_total   = {1'b0, shot_heat_q} + {1'b0, extra_heat_q};

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shl_pkg::ST_IDLE: begin
				if (in_xfer && (in_opcode == shl_pkg::OP_TICK)) begin
					state_d = shl_pkg::ST_DROP;
				end
			end
			shl_pkg::ST_DROP:   state_d = shl_pkg::ST_COOL;
			shl_pkg::ST_COOL:   state_d = shl_pkg::ST_GAIN;
			shl_pkg::ST_GAIN:   state_d = shl_pkg::ST_NEED;
			shl_pkg::ST_NEED:   state_d = shl_pkg::ST_BUDGET;
			shl_pkg::ST_BUDGET: begin
				if (budget_spent || (shot_heat_q == '0)) begin
					state_d = shl_pkg::ST_DONE;
				end else begin
					state_d = shl_pkg::ST_DIV_START;
				end
			end
			shl_pkg::ST_DIV_START: state_d = shl_pkg::ST_DIV_WAIT;
			shl_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = shl_pkg::ST_DONE;
				end
			end
			shl_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = shl_pkg::ST_IDLE;
				end
			end
			default: state_d = shl_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs, one multiplier job per step
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			shl_pkg::ST_IDLE: s_tready = 1'b1;
			shl_pkg::ST_DROP: begin
				// cooling drop over the tick period
				mul_a = fresh_q ? held_cooling_q : fb_cooling_q;
				mul_b = period_q;
			end
			shl_pkg::ST_COOL: begin
				// heat of one shot plus its safety extra
				mul_a = shl_pkg::MUL_A_W'(shot_total);
				mul_b = shl_pkg::MICRO_PER_UNIT;
			end
			shl_pkg::ST_GAIN: begin
				mul_a = margin_q;
				mul_b = shl_pkg::MICRO_PER_UNIT;
			end
			shl_pkg::ST_NEED: begin
				mul_a = fresh_q ? held_limit_q : fb_limit_q;
				mul_b = shl_pkg::MICRO_PER_UNIT;
			end
			shl_pkg::ST_BUDGET: begin
				// divisor for the shot count
				mul_a = shl_pkg::MUL_A_W'(shot_heat_q);
				mul_b = shl_pkg::MICRO_PER_UNIT;
			end
			shl_pkg::ST_DIV_START: div_start = 1'b1;
			shl_pkg::ST_DIV_WAIT:  ;
			shl_pkg::ST_DONE:      ;
			default:               ;
		endcase
	end

	// control state, registers and held status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= shl_pkg::ST_IDLE;
			shot_heat_q    <= shl_pkg::RST_SHOT_HEAT;
			extra_heat_q   <= shl_pkg::RST_EXTRA_HEAT;
			margin_q       <= shl_pkg::RST_MARGIN;
			fb_cooling_q   <= shl_pkg::RST_FB_COOLING;
			fb_limit_q     <= shl_pkg::RST_FB_LIMIT;
			stale_after_q  <= shl_pkg::RST_STALE_AFTER;
			heat_q         <= '0;
			fire_prev_q    <= 1'b0;
			held_cooling_q <= '0;
			held_limit_q   <= '0;
			held_valid_q   <= 1'b0;
			held_age_q     <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					shl_pkg::REG_SHOT_HEAT:   shot_heat_q   <= cfg_data[shl_pkg::SHOT_W-1:0];
					shl_pkg::REG_EXTRA_HEAT:  extra_heat_q  <= cfg_data[shl_pkg::SHOT_W-1:0];
					shl_pkg::REG_MARGIN:      margin_q      <= cfg_data[shl_pkg::MARGIN_W-1:0];
					shl_pkg::REG_FB_COOLING:  fb_cooling_q  <= cfg_data[shl_pkg::COOL_W-1:0];
					shl_pkg::REG_FB_LIMIT:    fb_limit_q    <= cfg_data[shl_pkg::LIMIT_W-1:0];
					shl_pkg::REG_STALE_AFTER: stale_after_q <= cfg_data[shl_pkg::AGE_W-1:0];
					default:                  ;
				endcase
			end

			if (in_xfer) begin
				if (in_opcode == shl_pkg::OP_STATUS) begin
					held_cooling_q <= in_cooling;
					held_limit_q   <= in_limit;
					held_valid_q   <= 1'b1;
					held_age_q     <= '0;
				end else begin
					held_age_q <= age_next;
				end
			end

			// cool down, floored at zero
			if (state_q == shl_pkg::ST_COOL) begin
				heat_q <= (heat_q > shl_pkg::HEAT_W'(prod_q))
				          ? heat_q - shl_pkg::HEAT_W'(prod_q) : '0;
			end

			// shot on a rising fire edge, saturating
			if (state_q == shl_pkg::ST_GAIN) begin
				fire_prev_q <= fire_q;
				if (fire_q && !fire_prev_q) begin
					heat_q <= heat_sum[shl_pkg::HEAT_W] ? '1 : heat_sum[shl_pkg::HEAT_W-1:0];
				end
			end

			// result register, loaded only once the previous result has left
			if ((state_q == shl_pkg::ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (out_xfer) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= shl_pkg::PROD_W'(mul_a) * shl_pkg::PROD_W'(mul_b);

		if (in_xfer) begin
			period_q <= in_period;
			fire_q   <= in_fire;
			fresh_q  <= fresh_next;
		end

		// heat plus reserve, both in micro-units
		if (state_q == shl_pkg::ST_NEED) begin
			need_q <= heat_sum;
		end

		if (state_q == shl_pkg::ST_BUDGET) begin
			// when the budget is not spent, need is below it and so fits in the product width
			diff_q <= prod_q - need_q[shl_pkg::PROD_W-1:0];
			if (budget_spent) begin
				shots_q <= '0;
			end else begin
				shots_q <= '1;
			end
		end

		if ((state_q == shl_pkg::ST_DIV_WAIT) && div_stat.done) begin
			shots_q <= quot[shl_pkg::QUOT_W-1] ? '1 : quot[shl_pkg::SHOTS_W-1:0];
		end

		if ((state_q == shl_pkg::ST_DONE) && out_free) begin
			m_shots_q <= shots_q;
			m_fresh_q <= fresh_q;
		end
	end

	shl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q),
		.divisor  (prod_q[shl_pkg::DIVISOR_W-1:0]),
		.quotient (quot),
		.stat     (div_stat)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_shots_q;
	assign m_tuser  = m_fresh_q;

	// divider completion only lands while the sequencer waits for it
	`SHL_ASSERT_IMPL(a_div_done_waited, clk, arst_n, div_stat.done,
		state_q == shl_pkg::ST_DIV_WAIT, "divider finished outside its wait step")

	// an accepted tick starts the sequence at the cooling drop
	`SHL_ASSERT_NEXT(a_tick_starts, clk, arst_n, in_xfer && (in_opcode == shl_pkg::OP_TICK),
		state_q == shl_pkg::ST_DROP, "tick transfer did not start the sequence")

	// a finished result never overwrites one still waiting downstream
	`SHL_ASSERT_NEXT(a_result_held, clk, arst_n,
		(state_q == shl_pkg::ST_DONE) && m_tvalid_q && !m_tready,
		state_q == shl_pkg::ST_DONE, "result loaded over a pending transfer")

endmodule

`default_nettype wire

// ===== rtl/shl_div.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on shl_pkg
`timescale 1ns / 1ps
`default_nettype none

module shl_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [shl_pkg::DIVIDEND_W-1:0]        dividend,
	input  wire logic [shl_pkg::DIVISOR_W-1:0]         divisor,
	output      logic [shl_pkg::QUOT_W-1:0]            quotient,
	output      shl_pkg::div_stat_t                    stat
);

	localparam int unsigned HI_W = shl_pkg::DIVIDEND_W - shl_pkg::QUOT_W;

	logic [shl_pkg::DIVISOR_W-1:0] rem_q;
	logic [shl_pkg::DIVISOR_W-1:0] div_q;
	logic [shl_pkg::QUOT_W-1:0]    low_q;
	logic [shl_pkg::QUOT_W-1:0]    quot_q;
	logic [shl_pkg::DCNT_W-1:0]    cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [shl_pkg::DIVISOR_W:0]   trial;
	logic                          fits;

	// bring down the next dividend bit and try the subtract
	assign trial = {rem_q, low_q[shl_pkg::QUOT_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= shl_pkg::DCNT_W'(shl_pkg::QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == shl_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// upper part is below the divisor since the divisor is at least 2^19
			rem_q  <= shl_pkg::DIVISOR_W'(dividend[shl_pkg::DIVIDEND_W-1 -: HI_W]);
			low_q  <= dividend[shl_pkg::QUOT_W-1:0];
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? shl_pkg::DIVISOR_W'(trial - {1'b0, div_q})
			               : trial[shl_pkg::DIVISOR_W-1:0];
			low_q  <= {low_q[shl_pkg::QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[shl_pkg::QUOT_W-2:0], fits};
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== tb/shot_heat_budget_limiter_tb.sv =====
// self-checking testbench for the shot heat budget limiter, directed and random transfers
// depends on shl_pkg and the shot_heat_budget_limiter top level, nothing else
`timescale 1ns / 1ps

module shot_heat_budget_limiter_tb;

	import shl_pkg::*;

	// register indexes past the end of the map, writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [63:0] MICRO      = 64'd1000000;
	localparam logic [63:0] HEAT_CAP   = 64'h00FF_FFFF_FFFF;
	localparam logic [63:0] SHOTS_CAP  = 64'd65535;
	localparam logic [31:0] AGE_CAP    = 32'hFFFF_FFFF;

	localparam int unsigned CYCLE_LIMIT    = 1500000;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned MAX_SHOWN      = 10;
	localparam int unsigned RAND_PHASES    = 6;
	localparam int unsigned RAND_PER_PHASE = 100;
	localparam int unsigned SOAK_TICKS     = 130;

	// one input item before packing onto the stream
	typedef struct packed {
		logic                op;
		logic [COOL_W-1:0]   cooling;
		logic [LIMIT_W-1:0]  limit;
		logic [PERIOD_W-1:0] period;
		logic                fire;
	} shl_item_t;

	// one predicted result
	typedef struct packed {
		logic [SHOTS_W-1:0] shots;
		logic               fresh;
	} budget_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [0:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;

	shot_heat_budget_limiter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // status_cooling[15:0], status_limit[31:16],
		                        // tick_period_us[51:32], fire_level[52]
		.s_tuser   (s_tuser),   // opcode[0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // shots_allowed[15:0]
		.m_tuser   (m_tuser)    // status_fresh[0]
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// items waiting for the driver, and shot budgets waiting for the monitor
	shl_item_t offer_q[$];
	budget_t   pending_budget[$];

	// shadow of the configuration registers, reset values
	logic [SHOT_W-1:0]   cur_shot_heat  = RST_SHOT_HEAT;
	logic [SHOT_W-1:0]   cur_extra_heat = RST_EXTRA_HEAT;
	logic [MARGIN_W-1:0] cur_margin     = RST_MARGIN;
	logic [COOL_W-1:0]   cur_fb_cooling = RST_FB_COOLING;
	logic [LIMIT_W-1:0]  cur_fb_limit   = RST_FB_LIMIT;
	logic [AGE_W-1:0]    cur_stale      = RST_STALE_AFTER;

	// predicted internal state of the limiter
	logic [HEAT_W-1:0]   heat_acc     = '0;
	logic                fire_last    = 1'b0;
	logic [COOL_W-1:0]   rep_cooling  = '0;
	logic [LIMIT_W-1:0]  rep_limit    = '0;
	logic                rep_valid    = 1'b0;
	logic [AGE_W-1:0]    rep_age      = '0;

	// bookkeeping
	int unsigned queued_cnt      = 0;
	int unsigned accepted_cnt    = 0;
	int unsigned status_seen     = 0;
	int unsigned ticks_seen      = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes      = 0;
	int unsigned err_cnt         = 0;
	int unsigned cycle_cnt       = 0;
	int unsigned send_idle_pct   = 0;
	int unsigned recv_idle_pct   = 0;
	int unsigned hold_req        = 0;
	int unsigned hold_served     = 0;
	int unsigned hold_left       = 0;
	logic        in_taken        = 1'b0;

	// advance the predicted limiter by one accepted item, queue the budget a tick gives
	task automatic apply_item(input logic op, input logic [IN_TDATA_W-1:0] data);
		logic [PERIOD_W-1:0] per;
		logic                fire;
		logic [32:0]         age_sum;
		logic                fresh;
		logic [63:0]         cool;
		logic [63:0]         lim;
		logic [63:0]         drop;
		logic [63:0]         heat;
		logic [63:0]         need;
		logic [63:0]         room;
		logic [63:0]         quot;
		budget_t             res;
		per  = data[51:32];
		fire = data[52];
		if (op == OP_STATUS) begin
			// a status transfer just refreshes the held report, no result
			rep_cooling = data[15:0];
			rep_limit   = data[31:16];
			rep_valid   = 1'b1;
			rep_age     = '0;
			status_seen++;
		end else begin
			ticks_seen++;
			// age the report first, saturating at the top of its range
			age_sum = {1'b0, rep_age} + 33'(per);
			rep_age = age_sum[32] ? AGE_CAP : age_sum[31:0];
			fresh = rep_valid && (cur_stale == '0 || rep_age <= cur_stale);
			cool  = fresh ? 64'(rep_cooling) : 64'(cur_fb_cooling);
			lim   = fresh ? 64'(rep_limit) : 64'(cur_fb_limit);
			// leak, floored at zero
			drop = cool * 64'(per);
			heat = 64'(heat_acc);
			heat = (heat > drop) ? heat - drop : 64'd0;
			// a rising edge of fire counts as one shot
			if (fire && !fire_last) begin
				heat = heat + (64'(cur_shot_heat) + 64'(cur_extra_heat)) * MICRO;
				if (heat > HEAT_CAP)
					heat = HEAT_CAP;
			end
			heat_acc  = heat[HEAT_W-1:0];
			fire_last = fire;
			need = heat + 64'(cur_margin) * MICRO;
			room = lim * MICRO;
			if (room <= need) begin
				quot = 64'd0;
			end else if (cur_shot_heat == '0) begin
				quot = SHOTS_CAP;
			end else begin
				quot = (room - need) / (64'(cur_shot_heat) * MICRO);
				if (quot > SHOTS_CAP)
					quot = SHOTS_CAP;
			end
			res.shots = quot[SHOTS_W-1:0];
			res.fresh = fresh;
			pending_budget.push_back(res);
		end
	endtask

	// input side: record each transfer and feed the predictor; result side: check in order
	always @(posedge clk) begin : monitor
		budget_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				accepted_cnt++;
				apply_item(s_tuser[0], s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (pending_budget.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display("%0t: result with none outstanding: shots %0d fresh %0b",
							$realtime, m_tdata, m_tuser[0]);
				end else begin
					want = pending_budget.pop_front();
					results_checked++;
					if (m_tdata !== want.shots || m_tuser[0] !== want.fresh) begin
						err_cnt++;
						if (err_cnt <= MAX_SHOWN)
							$display("%0t: result %0d: shots exp %0d got %0d, fresh exp %0b got %0b",
								$realtime, results_checked, want.shots, m_tdata,
								want.fresh, m_tuser[0]);
					end
				end
			end
		end
	end

	// driver: new item only once the previous transfer has gone, random gaps between items
	always @(negedge clk) begin : feed
		shl_item_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (offer_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = offer_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {3'b000, nxt.fire, nxt.period, nxt.limit, nxt.cooling};
				s_tuser  <= nxt.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, plus a long hold-off whenever one is requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_req) begin
			m_tready    <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left   <= LONG_HOLD;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: watchdog expired after %0d cycles", $realtime, cycle_cnt);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic offer(input logic op, input logic [COOL_W-1:0] cooling,
		input logic [LIMIT_W-1:0] limit, input logic [PERIOD_W-1:0] period, input logic fire);
		shl_item_t it;
		it.op      = op;
		it.cooling = cooling;
		it.limit   = limit;
		it.period  = period;
		it.fire    = fire;
		offer_q.push_back(it);
		queued_cnt++;
	endtask

	// one register write, shadow follows with the same masking the block applies
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_SHOT_HEAT:   cur_shot_heat  = val[SHOT_W-1:0];
			REG_EXTRA_HEAT:  cur_extra_heat = val[SHOT_W-1:0];
			REG_MARGIN:      cur_margin     = val[MARGIN_W-1:0];
			REG_FB_COOLING:  cur_fb_cooling = val[COOL_W-1:0];
			REG_FB_LIMIT:    cur_fb_limit   = val[LIMIT_W-1:0];
			REG_STALE_AFTER: cur_stale      = val[AGE_W-1:0];
			default: ;
		endcase
	endtask

	// sender pause: everything transferred, every result back, then let the block settle
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || offer_q.size() != 0 || pending_budget.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// extreme low, extreme high, or anything in between
	function automatic logic [31:0] pick_reg(input logic [31:0] lo, input logic [31:0] hi);
		int unsigned r;
		r = $urandom_range(3);
		if (r == 0)
			return lo;
		else if (r == 1)
			return hi;
		else
			return $urandom_range(hi, lo);
	endfunction

	initial begin
		int unsigned        r;
		logic               op;
		logic [COOL_W-1:0]  cool;
		logic [LIMIT_W-1:0] lim;
		logic [PERIOD_W-1:0] per;
		logic               fire;
		logic [31:0]        stale;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, register defaults: no report yet so fallback values apply
		offer(OP_TICK, 16'hFFFF, 16'hFFFF, 20'd1000, 1'b0);
		offer(OP_TICK, 16'h0000, 16'h0000, 20'd1000, 1'b1);    // rising edge, one shot
		offer(OP_TICK, 16'h5A5A, 16'hA5A5, 20'd0, 1'b1);       // fire held, zero period
		offer(OP_TICK, 16'h1234, 16'h4321, 20'd1000, 1'b0);
		// report with zero limit, tick fields carry junk
		offer(OP_STATUS, 16'd0, 16'd0, 20'hFFFFF, 1'b1);
		offer(OP_TICK, 16'hFFFF, 16'hFFFF, 20'd500, 1'b1);     // budget spent
		offer(OP_STATUS, 16'hFFFF, 16'hFFFF, 20'd0, 1'b0);
		offer(OP_TICK, 16'd0, 16'd0, 20'd499000, 1'b0);
		offer(OP_TICK, 16'd0, 16'd0, 20'd1000, 1'b0);          // age exactly on the limit
		offer(OP_TICK, 16'd0, 16'd0, 20'd1, 1'b1);             // one past, goes stale
		offer(OP_TICK, 16'd0, 16'd0, 20'hFFFFF, 1'b0);         // widest period
		offer(OP_STATUS, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1);
		offer(OP_TICK, 16'd0, 16'd0, 20'd1000000, 1'b1);
		offer(OP_TICK, 16'd0, 16'd0, 20'd0, 1'b0);
		wait_idle();

		// zero shot heat, widest margin, timeout disabled; spare indexes and junk high bits
		write_reg(REG_SHOT_HEAT, 32'hFFFF_FC00);
		write_reg(REG_EXTRA_HEAT, 32'd1000);
		write_reg(REG_MARGIN, 32'hA5A5_FFFF);
		write_reg(REG_FB_COOLING, 32'd0);
		write_reg(REG_FB_LIMIT, 32'h0000_FFFF);
		write_reg(REG_STALE_AFTER, 32'd0);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0001);
		offer(OP_STATUS, 16'hFFFF, 16'hFFFF, 20'd0, 1'b0);
		offer(OP_TICK, 16'd0, 16'd0, 20'hFFFFF, 1'b0);         // margin equals limit
		offer(OP_TICK, 16'd0, 16'd0, 20'd1000000, 1'b0);
		wait_idle();
		write_reg(REG_MARGIN, 32'd0);
		offer(OP_TICK, 16'd0, 16'd0, 20'd10, 1'b1);            // no divisor, budget left
		offer(OP_STATUS, 16'd0, 16'd100, 20'd0, 1'b0);
		offer(OP_TICK, 16'hFFFF, 16'hFFFF, 20'd10, 1'b0);      // no divisor, budget spent
		wait_idle();

		// random phases: receiver sparse then sender sparse then neither, two phases each
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(REG_SHOT_HEAT, pick_reg(32'd1, 32'd1000));
			write_reg(REG_EXTRA_HEAT, pick_reg(32'd0, 32'd1000));
			write_reg(REG_MARGIN, pick_reg(32'd0, 32'd65535));
			write_reg(REG_FB_COOLING, pick_reg(32'd0, 32'd65535));
			write_reg(REG_FB_LIMIT, pick_reg(32'd0, 32'd65535));
			r = $urandom_range(4);
			if (r == 0)
				stale = 32'd0;
			else if (r == 1)
				stale = 32'hFFFF_FFFF;
			else if (r == 2)
				stale = $urandom;
			else
				stale = $urandom_range(100000, 1000);
			write_reg(REG_STALE_AFTER, stale);

			// receiver holds off for a long stretch while the sender keeps offering
			if (ph == 4) begin
				@(posedge clk);
				hold_req++;
			end

			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				op   = ($urandom_range(99) < 15) ? OP_STATUS : OP_TICK;
				cool = $urandom_range(65535);
				lim  = $urandom_range(65535);
				fire = $urandom_range(1);
				r = $urandom_range(99);
				if (r < 60)
					per = PERIOD_W'($urandom_range(1500, 500));
				else if (r < 85)
					per = PERIOD_W'($urandom_range(1000000, 0));
				else if (r < 95)
					per = PERIOD_W'($urandom_range(100, 0));
				else
					per = r[0] ? PERIOD_W'(0) : PERIOD_W'(1000000);
				offer(op, cool, lim, per, fire);
			end
			wait_idle();
		end

		// soak: no cooling while the report stays fresh, so heat climbs with every shot
		// until the budget runs out
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_SHOT_HEAT, 32'd1000);
		write_reg(REG_EXTRA_HEAT, 32'd1000);
		write_reg(REG_MARGIN, 32'd0);
		write_reg(REG_FB_COOLING, 32'd65535);
		write_reg(REG_FB_LIMIT, 32'd65535);
		write_reg(REG_STALE_AFTER, 32'hFFFF_FFF0);
		offer(OP_STATUS, 16'd0, 16'd65535, 20'd0, 1'b0);
		for (int n = 0; n < SOAK_TICKS; n++) begin
			fire = logic'($urandom_range(1));
			offer(OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
				20'd1000000, fire);
		end
		wait_idle();

		$display("covered %0d status and %0d tick transfers over %0d register writes",
			status_seen, ticks_seen, reg_writes);
		$display("%0d shot budgets checked, %0d mismatches, %0d cycles",
			results_checked, err_cnt, cycle_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
